### hw/rtl/hrlp_pkg.sv
package hrlp_pkg;

    typedef enum logic [3:0] {
        PH_METHOD = 4'd0,
        PH_PATH   = 4'd1,
        PH_KEY    = 4'd2,
        PH_VALUE  = 4'd3,
        PH_PROTO  = 4'd4,
        PH_MAJOR  = 4'd5,
        PH_GAP    = 4'd6,
        PH_MINOR  = 4'd7,
        PH_DONE   = 4'd8
    } t_phase;

    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_METHOD = 3'd1;
    localparam logic [2:0] KIND_PATH   = 3'd2;
    localparam logic [2:0] KIND_KEY    = 3'd3;
    localparam logic [2:0] KIND_VALUE  = 3'd4;
    localparam logic [2:0] KIND_PROTO  = 3'd5;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    localparam int METHOD_MAX = 6;
    localparam int PROTO_MAX  = 4;

    localparam logic [2:0] METHOD_MAX_LEN = 3'(METHOD_MAX);
    localparam logic [2:0] PROTO_MAX_LEN  = 3'(PROTO_MAX);

    localparam logic [23:0] NAME_GET    = "GET";
    localparam logic [31:0] NAME_POST   = "POST";
    localparam logic [23:0] NAME_PUT    = "PUT";
    localparam logic [47:0] NAME_DELETE = "DELETE";
    localparam logic [31:0] NAME_HEAD   = "HEAD";
    localparam logic [31:0] NAME_HTTP   = "HTTP";

    typedef logic [METHOD_MAX-1:0][7:0] t_method_buf;
    typedef logic [PROTO_MAX-1:0][7:0]  t_proto_buf;

    typedef struct packed {
        logic [2:0] token_kind;
        logic [7:0] token_char;
        logic       pair_end;
        logic       line_done;
        logic [7:0] major_version;
        logic [7:0] minor_version;
        logic       line_good;
    } t_result;

endpackage

### hw/rtl/hrlp_name_check.sv
module hrlp_name_check (
    input  hrlp_pkg::t_method_buf i_method_chars,
    input  logic [2:0]            i_method_length,
    input  logic                  i_method_too_long,
    input  hrlp_pkg::t_proto_buf  i_proto_chars,
    input  logic [2:0]            i_proto_length,
    input  logic                  i_proto_too_long,
    output logic                  o_good
);
    import hrlp_pkg::*;

    logic [23:0] w_m3;
    logic [31:0] w_m4;
    logic [47:0] w_m6;
    logic [31:0] w_p4;
    logic        w_method_ok;
    logic        w_proto_ok;

    // entry 0 is the first character, so it lands in the top byte
    assign w_m3 = {i_method_chars[0], i_method_chars[1], i_method_chars[2]};
    assign w_m4 = {w_m3, i_method_chars[3]};
    assign w_m6 = {w_m4, i_method_chars[4], i_method_chars[5]};
    assign w_p4 = {i_proto_chars[0], i_proto_chars[1], i_proto_chars[2], i_proto_chars[3]};

    always_comb begin
        w_method_ok = !i_method_too_long &&
                      ((i_method_length == 3'd3 && (w_m3 == NAME_GET || w_m3 == NAME_PUT)) ||
                       (i_method_length == 3'd4 && (w_m4 == NAME_POST || w_m4 == NAME_HEAD)) ||
                       (i_method_length == 3'd6 && w_m6 == NAME_DELETE));
        w_proto_ok  = !i_proto_too_long && i_proto_length == PROTO_MAX_LEN &&
                      w_p4 == NAME_HTTP;
        o_good      = w_method_ok && w_proto_ok;
    end

endmodule

### hw/rtl/hrlp_parse.sv
module hrlp_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  logic [7:0]        i_byte,
    input  logic              i_start,
    output hrlp_pkg::t_result o_result
);
    import hrlp_pkg::*;

    t_phase      r_phase, n_phase, w_phase;
    t_method_buf r_method_chars;
    t_proto_buf  r_proto_chars;
    logic [2:0]  r_method_length, n_method_length, w_method_length;
    logic        r_method_too_long, n_method_too_long, w_method_too_long;
    logic [2:0]  r_proto_length, n_proto_length, w_proto_length;
    logic        r_proto_too_long, n_proto_too_long, w_proto_too_long;
    logic        r_key_seen, n_key_seen, w_key_seen;
    logic        r_value_seen, n_value_seen, w_value_seen;
    logic [7:0]  r_held_major, n_held_major, w_held_major;
    logic        w_method_we;
    logic        w_proto_we;
    logic        w_good;

    // a line start clears the phase, lengths, flags and held major digit before its byte is looked at
    always_comb begin
        w_phase           = i_start ? PH_METHOD : r_phase;
        w_method_length   = i_start ? 3'd0 : r_method_length;
        w_method_too_long = i_start ? 1'b0 : r_method_too_long;
        w_proto_length    = i_start ? 3'd0 : r_proto_length;
        w_proto_too_long  = i_start ? 1'b0 : r_proto_too_long;
        w_key_seen        = i_start ? 1'b0 : r_key_seen;
        w_value_seen      = i_start ? 1'b0 : r_value_seen;
        w_held_major      = i_start ? 8'd0 : r_held_major;
    end

    hrlp_name_check u_name_check (
        .i_method_chars   (r_method_chars),
        .i_method_length  (r_method_length),
        .i_method_too_long(r_method_too_long),
        .i_proto_chars    (r_proto_chars),
        .i_proto_length   (r_proto_length),
        .i_proto_too_long (r_proto_too_long),
        .o_good           (w_good)
    );

    always_comb begin
        n_phase           = w_phase;
        n_method_length   = w_method_length;
        n_method_too_long = w_method_too_long;
        n_proto_length    = w_proto_length;
        n_proto_too_long  = w_proto_too_long;
        n_key_seen        = w_key_seen;
        n_value_seen      = w_value_seen;
        n_held_major      = w_held_major;
        w_method_we       = 1'b0;
        w_proto_we        = 1'b0;
        o_result          = '0;
        unique case (w_phase)
            PH_METHOD: begin
                if (i_byte == CH_SPACE) begin
                    n_phase = PH_PATH;
                end else begin
                    o_result.token_kind = KIND_METHOD;
                    o_result.token_char = i_byte;
                    if (w_method_length < METHOD_MAX_LEN) begin
                        w_method_we     = 1'b1;
                        n_method_length = w_method_length + 3'd1;
                    end else begin
                        n_method_too_long = 1'b1;
                    end
                end
            end
            PH_PATH: begin
                if (i_byte == CH_SPACE) begin
                    n_phase = PH_PROTO;
                end else if (i_byte == CH_QMARK) begin
                    n_phase      = PH_KEY;
                    n_key_seen   = 1'b0;
                    n_value_seen = 1'b0;
                end else begin
                    o_result.token_kind = KIND_PATH;
                    o_result.token_char = i_byte;
                end
            end
            PH_KEY, PH_VALUE: begin
                if (i_byte == CH_SPACE) begin
                    o_result.pair_end = w_key_seen && w_value_seen;
                    n_phase           = PH_PROTO;
                end else if (i_byte == CH_AMP) begin
                    o_result.pair_end = 1'b1;
                    n_key_seen        = 1'b0;
                    n_value_seen      = 1'b0;
                    n_phase           = PH_KEY;
                end else if (w_phase == PH_KEY && i_byte == CH_EQ) begin
                    n_phase = PH_VALUE;
                end else if (w_phase == PH_KEY) begin
                    o_result.token_kind = KIND_KEY;
                    o_result.token_char = i_byte;
                    n_key_seen          = 1'b1;
                end else begin
                    o_result.token_kind = KIND_VALUE;
                    o_result.token_char = i_byte;
                    n_value_seen        = 1'b1;
                end
            end
            PH_PROTO: begin
                if (i_byte == CH_SLASH) begin
                    n_phase = PH_MAJOR;
                end else begin
                    o_result.token_kind = KIND_PROTO;
                    o_result.token_char = i_byte;
                    if (w_proto_length < PROTO_MAX_LEN) begin
                        w_proto_we     = 1'b1;
                        n_proto_length = w_proto_length + 3'd1;
                    end else begin
                        n_proto_too_long = 1'b1;
                    end
                end
            end
            PH_MAJOR: begin
                n_held_major = i_byte - CH_ZERO;
                n_phase      = PH_GAP;
            end
            PH_GAP: begin
                n_phase = PH_MINOR;
            end
            PH_MINOR: begin
                o_result.line_done     = 1'b1;
                o_result.major_version = w_held_major;
                o_result.minor_version = i_byte - CH_ZERO;
                o_result.line_good     = w_good;
                n_phase                = PH_DONE;
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_METHOD;
            r_method_length   <= 3'd0;
            r_method_too_long <= 1'b0;
            r_proto_length    <= 3'd0;
            r_proto_too_long  <= 1'b0;
            r_key_seen        <= 1'b0;
            r_value_seen      <= 1'b0;
            r_held_major      <= 8'd0;
        end else if (i_advance) begin
            r_phase           <= n_phase;
            r_method_length   <= n_method_length;
            r_method_too_long <= n_method_too_long;
            r_proto_length    <= n_proto_length;
            r_proto_too_long  <= n_proto_too_long;
            r_key_seen        <= n_key_seen;
            r_value_seen      <= n_value_seen;
            r_held_major      <= n_held_major;
        end
    end

    // name buffers hold payload only; entries past the length are never read
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < METHOD_MAX; i++) begin
            if (i_advance && w_method_we && w_method_length == 3'(i)) begin
                r_method_chars[i] <= i_byte;
            end
        end
        for (int j = 0; j < PROTO_MAX; j++) begin
            if (i_advance && w_proto_we && w_proto_length == 3'(j)) begin
                r_proto_chars[j] <= i_byte;
            end
        end
    end

endmodule

### hw/rtl/http_request_line_parser.sv
// Path: an accepted item waits in the input register and is parsed as it moves
//   into the result register, which must be empty or being drained at the time.
// Throughput: one item per cycle while results are taken; input and result
//   registers each hold one item, and parsing of the held byte happens between them.
// Reset: synchronous, active low; clears the parse phase, lengths and flags and
//   empties both registers. Name buffers are not cleared.
module http_request_line_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_line_byte,
    input  logic       i_line_start,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_token_kind,
    output logic [7:0] o_token_char,
    output logic       o_pair_end,
    output logic       o_line_done,
    output logic [7:0] o_major_version,
    output logic [7:0] o_minor_version,
    output logic       o_line_good
);
    import hrlp_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;

    // result register
    logic       r_out_valid;
    t_result    r_out;

    t_result    w_result;
    logic       w_advance;
    logic       w_accept;

    // advance the held byte when the result register is empty or being drained
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;
    assign w_accept   = i_in_valid && o_in_ready;

    hrlp_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_advance(w_advance),
        .i_byte   (r_in_byte),
        .i_start  (r_in_start),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // hold the input register unless a new item arrives or the old one leaves
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            // hold the result until taken; load a fresh one whenever the parser advances
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte  <= i_line_byte;
            r_in_start <= i_line_start;
        end
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_token_kind    = r_out.token_kind;
    assign o_token_char    = r_out.token_char;
    assign o_pair_end      = r_out.pair_end;
    assign o_line_done     = r_out.line_done;
    assign o_major_version = r_out.major_version;
    assign o_minor_version = r_out.minor_version;
    assign o_line_good     = r_out.line_good;

endmodule

### tb/http_request_line_parser_tb.sv
`timescale 1ns / 1ps

import hrlp_pkg::*;

// Scoreboard with a built-in model of the parser: each accepted byte advances
// the model and queues the tag it should produce; each taken result is checked
// against the oldest queued tag.
class line_scoreboard;
    t_phase     phase;
    logic [7:0] method_buf [METHOD_MAX];
    logic [2:0] method_len;
    bit         method_overflow;
    logic [7:0] proto_buf [PROTO_MAX];
    logic [2:0] proto_len;
    bit         proto_overflow;
    bit         key_nonempty;
    bit         value_nonempty;
    logic [7:0] major_digit;
    t_result    expected_tags [$];
    int         errors;
    int         parsed_bytes;

    function new();
        clear_line();
        errors       = 0;
        parsed_bytes = 0;
    endfunction

    function void clear_line();
        phase           = PH_METHOD;
        method_len      = '0;
        method_overflow = 1'b0;
        proto_len       = '0;
        proto_overflow  = 1'b0;
        key_nonempty    = 1'b0;
        value_nonempty  = 1'b0;
        major_digit     = '0;
        foreach (method_buf[i]) method_buf[i] = '0;
        foreach (proto_buf[i]) proto_buf[i] = '0;
    endfunction

    function int pending();
        return expected_tags.size();
    endfunction

    // Advance the model by one accepted byte and queue its tag.
    function void note_byte(logic [7:0] c, logic start);
        t_result     tag;
        logic [23:0] m3;
        logic [31:0] m4;
        logic [47:0] m6;
        logic [31:0] p4;
        bit          method_ok;
        bit          proto_ok;
        tag = '0;
        if (start) clear_line();
        if (phase != PH_DONE) parsed_bytes++;
        case (phase)
            PH_METHOD: begin
                if (c == CH_SPACE) begin
                    phase = PH_PATH;
                end else begin
                    tag.token_kind = KIND_METHOD;
                    tag.token_char = c;
                    if (method_len < METHOD_MAX_LEN) begin
                        method_buf[method_len] = c;
                        method_len++;
                    end else begin
                        method_overflow = 1'b1;
                    end
                end
            end
            PH_PATH: begin
                if (c == CH_SPACE) begin
                    phase = PH_PROTO;
                end else if (c == CH_QMARK) begin
                    phase          = PH_KEY;
                    key_nonempty   = 1'b0;
                    value_nonempty = 1'b0;
                end else begin
                    tag.token_kind = KIND_PATH;
                    tag.token_char = c;
                end
            end
            PH_KEY, PH_VALUE: begin
                if (c == CH_SPACE) begin
                    // last pair survives only with both halves present
                    tag.pair_end = key_nonempty && value_nonempty;
                    phase        = PH_PROTO;
                end else if (c == CH_AMP) begin
                    tag.pair_end   = 1'b1;
                    key_nonempty   = 1'b0;
                    value_nonempty = 1'b0;
                    phase          = PH_KEY;
                end else if (phase == PH_KEY && c == CH_EQ) begin
                    phase = PH_VALUE;
                end else if (phase == PH_KEY) begin
                    tag.token_kind = KIND_KEY;
                    tag.token_char = c;
                    key_nonempty   = 1'b1;
                end else begin
                    tag.token_kind = KIND_VALUE;
                    tag.token_char = c;
                    value_nonempty = 1'b1;
                end
            end
            PH_PROTO: begin
                if (c == CH_SLASH) begin
                    phase = PH_MAJOR;
                end else begin
                    tag.token_kind = KIND_PROTO;
                    tag.token_char = c;
                    if (proto_len < PROTO_MAX_LEN) begin
                        proto_buf[proto_len] = c;
                        proto_len++;
                    end else begin
                        proto_overflow = 1'b1;
                    end
                end
            end
            PH_MAJOR: begin
                major_digit = c - CH_ZERO;
                phase       = PH_GAP;
            end
            PH_GAP: phase = PH_MINOR;
            PH_MINOR: begin
                m3 = {method_buf[0], method_buf[1], method_buf[2]};
                m4 = {m3, method_buf[3]};
                m6 = {m4, method_buf[4], method_buf[5]};
                p4 = {proto_buf[0], proto_buf[1], proto_buf[2], proto_buf[3]};
                method_ok = !method_overflow &&
                            ((method_len == 3'd3 && (m3 == NAME_GET || m3 == NAME_PUT)) ||
                             (method_len == 3'd4 && (m4 == NAME_POST || m4 == NAME_HEAD)) ||
                             (method_len == 3'd6 && m6 == NAME_DELETE));
                proto_ok = !proto_overflow && proto_len == 3'd4 && p4 == NAME_HTTP;
                tag.line_done     = 1'b1;
                tag.major_version = major_digit;
                tag.minor_version = c - CH_ZERO;
                tag.line_good     = method_ok && proto_ok;
                phase             = PH_DONE;
            end
            default: phase = PH_DONE;
        endcase
        expected_tags.insert(expected_tags.size(), tag);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function void check_result(t_result got);
        t_result want;
        if (expected_tags.size() == 0) begin
            $error("result with no byte pending: %p", got);
            errors++;
        end else begin
            want = expected_tags.pop_front();
            compare_field("token_kind", 8'(want.token_kind), 8'(got.token_kind));
            compare_field("token_char", want.token_char, got.token_char);
            compare_field("pair_end", 8'(want.pair_end), 8'(got.pair_end));
            compare_field("line_done", 8'(want.line_done), 8'(got.line_done));
            compare_field("major_version", want.major_version, got.major_version);
            compare_field("minor_version", want.minor_version, got.minor_version);
            compare_field("line_good", 8'(want.line_good), 8'(got.line_good));
        end
    endfunction
endclass

module http_request_line_parser_tb;

    localparam int CYCLE_LIMIT  = 150000;
    localparam int BYTE_TARGET  = 1300;
    localparam int TAIL_CYCLES  = 8;
    localparam int LONG_HOLD    = 80;
    localparam int HOLD_TRIGGER = 400;

    // character classes for random line content
    localparam int CTX_METHOD = 0;
    localparam int CTX_PATH   = 1;
    localparam int CTX_KEY    = 2;
    localparam int CTX_VALUE  = 3;
    localparam int CTX_PROTO  = 4;

    localparam logic [7:0] CH_DOT    = ".";
    localparam logic [7:0] CH_LOWBIT = 8'h20;

    // known line: leading bytes without a start flag, a key missing its '=',
    // an empty key with a value, and an ignored tail after the minor digit
    localparam int          DIRECTED_LEN  = 23;
    localparam logic [183:0] DIRECTED_LINE = "GET /?a=b&c&=d HTTP/1.1";

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_line_byte;
    logic       i_line_start;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [2:0] o_token_kind;
    logic [7:0] o_token_char;
    logic       o_pair_end;
    logic       o_line_done;
    logic [7:0] o_major_version;
    logic [7:0] o_minor_version;
    logic       o_line_good;

    line_scoreboard sb;
    t_result        result_seen;
    logic [7:0]     line_q [$];
    int             burst_left;
    int             cycles;
    int             results_taken;
    int             hold_left;
    bit             long_hold_done;
    int             rx_mode;
    int             rx_period;
    int             rx_tick;
    int             rx_left;

    http_request_line_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_line_byte     (i_line_byte),
        .i_line_start    (i_line_start),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_token_kind    (o_token_kind),
        .o_token_char    (o_token_char),
        .o_pair_end      (o_pair_end),
        .o_line_done     (o_line_done),
        .o_major_version (o_major_version),
        .o_minor_version (o_minor_version),
        .o_line_good     (o_line_good)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Pick a random byte that cannot end the current token. Mostly printable,
    // now and then anything at all so every bit toggles.
    function automatic logic [7:0] pick_char(input int ctx);
        logic [7:0] c;
        bit         bad;
        do begin
            if ($urandom_range(0, 7) == 0)
                c = 8'($urandom_range(0, 255));
            else
                c = 8'($urandom_range(8'h21, 8'h7E));
            case (ctx)
                CTX_METHOD: bad = (c == CH_SPACE);
                CTX_PATH:   bad = (c == CH_SPACE) || (c == CH_QMARK);
                CTX_KEY:    bad = (c == CH_SPACE) || (c == CH_AMP) || (c == CH_EQ);
                CTX_VALUE:  bad = (c == CH_SPACE) || (c == CH_AMP);
                default:    bad = (c == CH_SLASH);
            endcase
        end while (bad);
        return c;
    endfunction

    function automatic logic [7:0] pick_digit();
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom_range(0, 255));
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // Append one byte to the line under construction.
    function automatic void append_byte(input logic [7:0] b);
        line_q.insert(line_q.size(), b);
    endfunction

    task automatic add_name(input logic [47:0] txt, input int n);
        for (int i = n - 1; i >= 0; i--) append_byte(txt[8*i +: 8]);
    endtask

    // Offer one item and hold it until the block takes it. Open a random
    // gap whenever the current burst runs out.
    task automatic send_item(input logic [7:0] b, input logic s);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_line_byte  <= b;
        i_line_start <= s;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_byte(b, s);
    endtask

    // Build a mostly well-formed request line with random content in line_q.
    task automatic build_line();
        logic [47:0] nm;
        int          nl;
        int          pairs;
        nm = '0;
        nl = 0;
        line_q.delete();
        case ($urandom_range(0, 6))
            0: begin nm = 48'(NAME_GET);    nl = 3; end
            1: begin nm = 48'(NAME_POST);   nl = 4; end
            2: begin nm = 48'(NAME_PUT);    nl = 3; end
            3: begin nm = NAME_DELETE;      nl = 6; end
            4: begin nm = 48'(NAME_HEAD);   nl = 4; end
            default: nl = 0;
        endcase
        if (nl != 0) begin
            add_name(nm, nl);
            // now and then spoil the name by one letter
            case ($urandom_range(0, 7))
                0: void'(line_q.pop_back());
                1: append_byte(pick_char(CTX_METHOD));
                2: line_q[0] = line_q[0] ^ CH_LOWBIT;
                default: ;
            endcase
        end else begin
            // random method, empty up to overlong
            repeat ($urandom_range(0, 9)) append_byte(pick_char(CTX_METHOD));
        end
        append_byte(CH_SPACE);
        if ($urandom_range(0, 7) != 0) append_byte(CH_SLASH);
        repeat ($urandom_range(0, 5)) append_byte(pick_char(CTX_PATH));
        if ($urandom_range(0, 9) < 7) begin
            append_byte(CH_QMARK);
            pairs = $urandom_range(1, 3);
            for (int p = 0; p < pairs; p++) begin
                if (p != 0) append_byte(CH_AMP);
                repeat ($urandom_range(0, 3)) append_byte(pick_char(CTX_KEY));
                if ($urandom_range(0, 6) != 0) begin
                    append_byte(CH_EQ);
                    repeat ($urandom_range(0, 3)) append_byte(pick_char(CTX_VALUE));
                end
            end
            if ($urandom_range(0, 7) == 0) append_byte(CH_AMP);
        end
        append_byte(CH_SPACE);
        case ($urandom_range(0, 9))
            7: begin
                add_name(48'(NAME_HTTP), 4);
                append_byte(pick_char(CTX_PROTO));
            end
            8: begin
                add_name(48'(NAME_HTTP), 4);
                void'(line_q.pop_back());
            end
            9: repeat ($urandom_range(0, 6)) append_byte(pick_char(CTX_PROTO));
            default: add_name(48'(NAME_HTTP), 4);
        endcase
        append_byte(CH_SLASH);
        append_byte(pick_digit());
        append_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : CH_DOT);
        append_byte(pick_digit());
        // trailing bytes after the minor digit are ignored by the parser
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 3)) append_byte(8'($urandom_range(0, 255)));
    endtask

    // Stimulus: reset, the known line, then random lines until enough bytes
    // have gone through the parser.
    initial begin
        int  cut;
        logic start_flag;
        sb             = new();
        burst_left     = 0;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_line_byte    <= '0;
        i_line_start   <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no start flag here: the line counts as begun at reset
        for (int i = DIRECTED_LEN - 1; i >= 0; i--) send_item(DIRECTED_LINE[8*i +: 8], 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);

        while (sb.parsed_bytes < BYTE_TARGET) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise: raw bytes with stray start flags
                repeat ($urandom_range(1, 20))
                    send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 7) == 0));
            end else begin
                build_line();
                // cut some lines short so the next start flag breaks them off
                if ($urandom_range(0, 9) == 0) begin
                    cut = $urandom_range(1, line_q.size());
                    while (line_q.size() > cut) void'(line_q.pop_back());
                end
                start_flag = ($urandom_range(0, 19) != 0);
                foreach (line_q[i]) send_item(line_q[i], (i == 0) ? start_flag : 1'b0);
            end
        end
        i_in_valid <= 1'b0;

        // drain, then give the block time to show any stray result
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Receiver: check what is taken at this edge, then choose ready for the
    // next one. Patterns change every so often; once, hold off long enough
    // for the parser to fill up and push back on the sender.
    initial begin
        i_out_ready    <= 1'b0;
        results_taken  = 0;
        hold_left      = 0;
        long_hold_done = 1'b0;
        rx_mode        = 0;
        rx_period      = 1;
        rx_tick        = 0;
        rx_left        = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            result_seen.token_kind    = o_token_kind;
            result_seen.token_char    = o_token_char;
            result_seen.pair_end      = o_pair_end;
            result_seen.line_done     = o_line_done;
            result_seen.major_version = o_major_version;
            result_seen.minor_version = o_minor_version;
            result_seen.line_good     = o_line_good;
            sb.check_result(result_seen);
            results_taken++;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (!long_hold_done && results_taken >= HOLD_TRIGGER) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD;
            i_out_ready    <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode   = $urandom_range(0, 2);
                rx_period = $urandom_range(2, 5);
                rx_left   = $urandom_range(20, 120);
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= 1'($urandom_range(0, 3) != 0);
                default: i_out_ready <= (rx_tick % rx_period) == 0;
            endcase
        end
    end

    // Watchdog: stop a hung run.
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule

### sim.f
hw/rtl/hrlp_pkg.sv
hw/rtl/hrlp_name_check.sv
hw/rtl/hrlp_parse.sv
hw/rtl/http_request_line_parser.sv
tb/http_request_line_parser_tb.sv
